// ----- rtl/smsc_pkg.sv -----
// Shared types, opcodes and sizes for the single-cycle MIPS subset core.
package smsc_pkg;

   localparam int DATA_MEM_BYTES_DEF = 65536;
   localparam int XLEN               = 32;
   localparam int REG_COUNT          = 32;
   localparam int REG_ADDR_W         = 5;

   localparam logic CMD_EXEC    = 1'b0;
   localparam logic CMD_PRELOAD = 1'b1;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_ADDU = 6'd33;
   localparam logic [5:0] FN_SUBU = 6'd35;
   localparam logic [5:0] FN_AND  = 6'd36;
   localparam logic [5:0] FN_OR   = 6'd37;
   localparam logic [5:0] FN_NOR  = 6'd39;

   localparam logic [XLEN-1:0] HALT_WORD = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        cmd;
      logic [31:0] instr_word;
      logic [15:0] load_addr;
      logic [7:0]  load_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] cur_pc;
      logic [31:0] next_pc;
      logic        reg_wr_en;
      logic [4:0]  reg_wr_addr;
      logic [31:0] reg_wr_data;
      logic        mem_wr_en;
      logic [31:0] mem_wr_addr;
      logic [31:0] mem_wr_data;
      logic        halted;
   } rsp_type;

   // Register file write port, also used as a forwarding entry.
   typedef struct packed {
      logic                  en;
      logic [REG_ADDR_W-1:0] addr;
      logic [XLEN-1:0]       data;
   } rf_wr_type;

   // Data memory access command.
   typedef struct packed {
      logic            rd;
      logic            wr_word;
      logic            wr_byte;
      logic [XLEN-1:0] addr;
      logic [XLEN-1:0] data;
   } dmem_cmd_type;

endpackage

// ----- rtl/smsc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module smsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/smsc_rf.sv -----
// Register file: two RAM copies for two read ports, valid bits for reset-to-zero.
module smsc_rf (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             rd_en,
   input  logic [smsc_pkg::REG_ADDR_W-1:0]  rs_addr,
   input  logic [smsc_pkg::REG_ADDR_W-1:0]  rt_addr,
   input  smsc_pkg::rf_wr_type              wr,
   output logic [smsc_pkg::XLEN-1:0]        rs_data,
   output logic [smsc_pkg::XLEN-1:0]        rt_data
);

   logic [smsc_pkg::REG_COUNT-1:0] valid_ff;
   logic                           rs_ok_ff;
   logic                           rt_ok_ff;
   logic [smsc_pkg::XLEN-1:0]      rs_ram;
   logic [smsc_pkg::XLEN-1:0]      rt_ram;

   smsc_ram #(
      .WIDTH (smsc_pkg::XLEN),
      .DEPTH (smsc_pkg::REG_COUNT)
   ) u_ram_rs (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rs_addr),
      .rd_data (rs_ram)
   );

   smsc_ram #(
      .WIDTH (smsc_pkg::XLEN),
      .DEPTH (smsc_pkg::REG_COUNT)
   ) u_ram_rt (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr.addr),
      .wr_data (wr.data),
      .rd_en   (rd_en),
      .rd_addr (rt_addr),
      .rd_data (rt_ram)
   );

   // Mark written entries; capture validity alongside the RAM read.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rs_ok_ff <= 1'b0;
         rt_ok_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rs_ok_ff <= valid_ff[rs_addr];
            rt_ok_ff <= valid_ff[rt_addr];
         end
      end
   end

   assign rs_data = rs_ok_ff ? rs_ram : '0;
   assign rt_data = rt_ok_ff ? rt_ram : '0;

endmodule

// ----- rtl/smsc_dmem.sv -----
// Big-endian byte data memory as four byte banks for unaligned word access.
module smsc_dmem #(
   parameter int DATA_MEM_BYTES = smsc_pkg::DATA_MEM_BYTES_DEF
) (
   input  logic                        clock,
   input  smsc_pkg::dmem_cmd_type      cmd,
   output logic [smsc_pkg::XLEN-1:0]   rd_word
);

   localparam int ADDR_W = $clog2(DATA_MEM_BYTES);
   localparam int ROW_W  = ADDR_W - 2;
   localparam int ROWS   = DATA_MEM_BYTES / 4;

   logic [ROW_W-1:0] row_base;
   logic [1:0]       ofs;
   logic [1:0]       ofs_ff;
   logic [ROW_W-1:0] bank_row   [4];
   logic [7:0]       bank_wdata [4];
   logic [7:0]       bank_q     [4];
   logic [3:0]       bank_we;

   assign row_base = cmd.addr[ADDR_W-1:2];
   assign ofs      = cmd.addr[1:0];

   // Byte i of the word sits in bank (ofs + i); banks below ofs wrap to the next row.
   always_comb begin
      logic [1:0] idx;
      idx = '0;
      for (int b = 0; b < 4; b++) begin
         idx           = 2'(b) - ofs;
         bank_row[b]   = row_base + {{(ROW_W-1){1'b0}}, (2'(b) < ofs)};
         bank_wdata[b] = cmd.wr_word ? cmd.data[{~idx, 3'b000} +: 8] : cmd.data[7:0];
         bank_we[b]    = cmd.wr_word || (cmd.wr_byte && (ofs == 2'(b)));
      end
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      smsc_ram #(
         .WIDTH (8),
         .DEPTH (ROWS)
      ) u_bank (
         .clock   (clock),
         .wr_en   (bank_we[b]),
         .wr_addr (bank_row[b]),
         .wr_data (bank_wdata[b]),
         .rd_en   (cmd.rd),
         .rd_addr (bank_row[b]),
         .rd_data (bank_q[b])
      );
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         ofs_ff <= ofs;
      end
   end

   // Reassemble the word, most significant byte from the lowest address.
   always_comb begin
      logic [1:0] sel;
      sel = '0;
      for (int i = 0; i < 4; i++) begin
         sel                  = ofs_ff + 2'(i);
         rd_word[31-8*i -: 8] = bank_q[sel];
      end
   end

endmodule

// ----- rtl/single_cycle_mips_subset_core.sv -----
// Top level of the MIPS subset core: request pipeline, execute logic and result register.
//
// Usage:
//   Requests arrive on req_valid/req_ready with a req_payload. An execute request
//   (cmd 0) carries the instruction word fetched at the next_pc of the previous
//   result; a preload request (cmd 1) writes one data memory byte and returns nothing.
//   Each execute request returns one result on rsp_valid/rsp_ready with the
//   executed pc, the next pc, and any register or memory write.
//   A result shows on rsp_valid once its request has passed the register read at
//   the accepting edge, execute and data memory access, and write back into the
//   result register. Throughput: one request per cycle unless rsp_ready stalls the
//   results, set by the registered register file read and the single data memory
//   access per request; loads forward to the next request, so there is no interlock.
//   Stall: when rsp_ready is low the result register holds; the two internal stages
//   keep filling, and req_ready drops only once every stage is occupied.
//   Reset: synchronous, active high; pc, halt flag and all registers read as zero.
//   Data memory content is undefined until written; no clearing pass is run.
//   An all-ones instruction halts the core; later execute requests report halted.
//   DATA_MEM_BYTES must be a power of two; data addresses wrap modulo its size.
module single_cycle_mips_subset_core #(
   parameter int DATA_MEM_BYTES = smsc_pkg::DATA_MEM_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  smsc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smsc_pkg::rsp_type rsp_payload
);

   localparam int XLEN = smsc_pkg::XLEN;

   // Stage 1: register operands arrive from the RAMs.
   logic                   s1_valid_ff;
   smsc_pkg::req_type      s1_req_ff;
   smsc_pkg::rf_wr_type    s1_fwd_ff;
   // Stage 2: data memory read data arrives, register write back.
   logic                   s2_valid_ff;
   logic                   s2_has_rsp_ff;
   logic                   s2_load_ff;
   smsc_pkg::rsp_type      s2_rsp_ff;
   // Result register.
   logic                   out_valid_ff;
   smsc_pkg::rsp_type      out_ff;
   smsc_pkg::rsp_type      out_in;
   // Architectural pc and halt flag.
   logic [XLEN-1:0]        pc_ff;
   logic                   halt_ff;

   logic                   out_free;
   logic                   s2_move;
   logic                   s1_move;
   logic                   accept;

   smsc_pkg::rf_wr_type    rf_wr;
   logic [XLEN-1:0]        rf_rs;
   logic [XLEN-1:0]        rf_rt;
   logic [XLEN-1:0]        dmem_word;
   logic [XLEN-1:0]        s2_wdata;
   smsc_pkg::dmem_cmd_type dmem_cmd;

   logic [XLEN-1:0]        pc_in;
   logic                   halt_in;
   logic                   s2_has_rsp_in;
   logic                   s2_load_in;
   smsc_pkg::rsp_type      s2_rsp_in;

   // Handshake: each stage advances when the one ahead is empty or advancing.
   assign out_free  = !out_valid_ff || rsp_ready;
   assign s2_move   = s2_valid_ff && (!s2_has_rsp_ff || out_free);
   assign s1_move   = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // Write back from stage 2 as it retires.
   assign s2_wdata   = s2_load_ff ? dmem_word : s2_rsp_ff.reg_wr_data;
   assign rf_wr.en   = s2_move && s2_rsp_ff.reg_wr_en;
   assign rf_wr.addr = s2_rsp_ff.reg_wr_addr;
   assign rf_wr.data = s2_wdata;

   smsc_rf u_rf (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rs_addr (req_payload.instr_word[25:21]),
      .rt_addr (req_payload.instr_word[20:16]),
      .wr      (rf_wr),
      .rs_data (rf_rs),
      .rt_data (rf_rt)
   );

   smsc_dmem #(
      .DATA_MEM_BYTES (DATA_MEM_BYTES)
   ) u_dmem (
      .clock   (clock),
      .cmd     (dmem_cmd),
      .rd_word (dmem_word)
   );

   // Execute: forward operands, decode, compute pc, write values and memory access.
   always_comb begin
      logic [5:0]                      op;
      logic [5:0]                      fn;
      logic [smsc_pkg::REG_ADDR_W-1:0] rs;
      logic [smsc_pkg::REG_ADDR_W-1:0] rt;
      logic [smsc_pkg::REG_ADDR_W-1:0] rd;
      logic [XLEN-1:0]                 simm;
      logic [XLEN-1:0]                 a;
      logic [XLEN-1:0]                 b;
      logic [XLEN-1:0]                 pc4;
      logic [XLEN-1:0]                 sum_imm;
      logic                            wen;
      logic [smsc_pkg::REG_ADDR_W-1:0] waddr;
      logic [XLEN-1:0]                 wdata;
      logic                            is_load;
      logic                            is_store;

      op      = s1_req_ff.instr_word[31:26];
      fn      = s1_req_ff.instr_word[5:0];
      rs      = s1_req_ff.instr_word[25:21];
      rt      = s1_req_ff.instr_word[20:16];
      rd      = s1_req_ff.instr_word[15:11];
      simm    = {{16{s1_req_ff.instr_word[15]}}, s1_req_ff.instr_word[15:0]};

      // Newest write wins: stage 2 pending, then the write taken at the read edge.
      if (s2_valid_ff && s2_rsp_ff.reg_wr_en && (s2_rsp_ff.reg_wr_addr == rs)) begin
         a = s2_wdata;
      end else if (s1_fwd_ff.en && (s1_fwd_ff.addr == rs)) begin
         a = s1_fwd_ff.data;
      end else begin
         a = rf_rs;
      end
      if (s2_valid_ff && s2_rsp_ff.reg_wr_en && (s2_rsp_ff.reg_wr_addr == rt)) begin
         b = s2_wdata;
      end else if (s1_fwd_ff.en && (s1_fwd_ff.addr == rt)) begin
         b = s1_fwd_ff.data;
      end else begin
         b = rf_rt;
      end

      pc4      = pc_ff + 32'd4;
      sum_imm  = a + simm;
      wen      = 1'b0;
      waddr    = '0;
      wdata    = '0;
      is_load  = 1'b0;
      is_store = 1'b0;

      s2_rsp_in         = '0;
      s2_rsp_in.cur_pc  = pc_ff;
      s2_rsp_in.next_pc = pc4;
      pc_in             = pc_ff;
      halt_in           = halt_ff;
      s2_has_rsp_in     = 1'b0;

      if (s1_req_ff.cmd == smsc_pkg::CMD_EXEC) begin
         s2_has_rsp_in = 1'b1;
         if (halt_ff || (s1_req_ff.instr_word == smsc_pkg::HALT_WORD)) begin
            // Halt: report the same pc, change nothing else.
            halt_in           = 1'b1;
            s2_rsp_in.next_pc = pc_ff;
            s2_rsp_in.halted  = 1'b1;
         end else begin
            case (op)
               smsc_pkg::OP_SPECIAL: begin
                  waddr = rd;
                  wen   = 1'b1;
                  case (fn)
                     smsc_pkg::FN_ADDU: wdata = a + b;
                     smsc_pkg::FN_SUBU: wdata = a - b;
                     smsc_pkg::FN_AND:  wdata = a & b;
                     smsc_pkg::FN_OR:   wdata = a | b;
                     smsc_pkg::FN_NOR:  wdata = ~(a | b);
                     default:           wen   = 1'b0;
                  endcase
               end
               smsc_pkg::OP_ADDIU: begin
                  wen   = 1'b1;
                  waddr = rt;
                  wdata = sum_imm;
               end
               smsc_pkg::OP_LW: begin
                  wen     = 1'b1;
                  waddr   = rt;
                  is_load = 1'b1;
               end
               smsc_pkg::OP_SW: begin
                  is_store              = 1'b1;
                  s2_rsp_in.mem_wr_en   = 1'b1;
                  s2_rsp_in.mem_wr_addr = sum_imm;
                  s2_rsp_in.mem_wr_data = b;
               end
               smsc_pkg::OP_BEQ: begin
                  if (a == b) begin
                     s2_rsp_in.next_pc = pc4 + {simm[XLEN-3:0], 2'b00};
                  end
               end
               smsc_pkg::OP_J: begin
                  s2_rsp_in.next_pc = {pc4[31:28], s1_req_ff.instr_word[25:0], 2'b00};
               end
               default: begin
                  // Unknown opcode: no-op, fall through to pc+4.
               end
            endcase
            // Drop writes to register zero.
            if (wen && (waddr != '0)) begin
               s2_rsp_in.reg_wr_en   = 1'b1;
               s2_rsp_in.reg_wr_addr = waddr;
               s2_rsp_in.reg_wr_data = wdata;
            end else begin
               is_load = 1'b0;
            end
            pc_in = s2_rsp_in.next_pc;
         end
      end

      s2_load_in = is_load;

      dmem_cmd.rd      = s1_move && is_load;
      dmem_cmd.wr_word = s1_move && is_store;
      dmem_cmd.wr_byte = s1_move && (s1_req_ff.cmd == smsc_pkg::CMD_PRELOAD);
      dmem_cmd.addr    = (s1_req_ff.cmd == smsc_pkg::CMD_PRELOAD) ?
                         {16'd0, s1_req_ff.load_addr} : sum_imm;
      dmem_cmd.data    = (s1_req_ff.cmd == smsc_pkg::CMD_PRELOAD) ?
                         {24'd0, s1_req_ff.load_byte} : b;
   end

   // Result fields, with the loaded word in place of the staged write data.
   always_comb begin
      out_in             = s2_rsp_ff;
      out_in.reg_wr_data = s2_wdata;
   end

   // Control state: stage valids, pc, halt flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s2_has_rsp_ff <= 1'b0;
         s2_load_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
         pc_ff         <= '0;
         halt_ff       <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end

         if (s1_move) begin
            s2_valid_ff   <= 1'b1;
            s2_has_rsp_ff <= s2_has_rsp_in;
            s2_load_ff    <= s2_load_in;
            pc_ff         <= pc_in;
            halt_ff       <= halt_in;
         end else if (s2_move) begin
            s2_valid_ff   <= 1'b0;
         end

         if (s2_move && s2_has_rsp_ff) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: request, forwarding entry and result fields.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_payload;
         // Hold the write retiring at the read edge; the RAM returns old data for it.
         s1_fwd_ff <= rf_wr;
      end
      if (s1_move) begin
         s2_rsp_ff <= s2_rsp_in;
      end
      if (s2_move && s2_has_rsp_ff) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

endmodule
